FILE: hdl/gdfs_pkg.sv
// Shared types and constants for the depth-first reachability core.
// Holds the result codes and the controller/datapath command and status structs.
`default_nettype none
package gdfs_pkg;

  localparam int VERTEX_COUNT_DEF = 16;
  localparam int MAX_DEGREE_DEF   = 16;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_FINAL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } add_status_t;

  typedef struct packed {
    logic        latch_in;
    logic        deg_rd;
    logic        deg_sel_cur;
    logic        deg_load;
    logic        idx_clr;
    logic        idx_inc;
    logic        nb_rd;
    logic        nb_sel_query;
    logic        nb_wr;
    logic        q_init;
    logic        cur_inc;
    logic        push;
    logic        pop_rd;
    logic        pop_load;
    logic        emit_add;
    logic        emit_edge;
    logic        emit_fin;
    add_status_t add_status;
  } gdfs_cmd_t;

  typedef struct packed {
    logic is_query;
    logic a_ok;
    logic b_ok;
    logic idx_lt_deg;
    logic deg_full;
    logic cur_done;
    logic stack_empty;
    logic nb_match;
    logic w_visited;
    logic out_free;
  } gdfs_stat_t;

endpackage
`default_nettype wire

FILE: hdl/gdfs_if.sv
// Request and result channel interfaces of the reachability core.
// Independent of the package; payload widths follow the fixed field widths.
`default_nettype none
interface gdfs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] vertex_a;
  logic [3:0] vertex_b;
  modport source (output valid, command, vertex_a, vertex_b, input ready);
  modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

interface gdfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] status;
  logic [3:0] edge_from;
  logic [3:0] edge_to;
  logic       reachable;
  logic       last;
  modport source (output valid, kind, status, edge_from, edge_to, reachable, last,
                  input ready);
  modport sink   (input valid, kind, status, edge_from, edge_to, reachable, last,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/gdfs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module gdfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: hdl/gdfs_ctrl.sv
// Controller state machine of the reachability core.
// Uses gdfs_pkg; drives the datapath by command struct and reads its status.
`default_nettype none
module gdfs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  output logic                    in_ready,
  input  wire gdfs_pkg::gdfs_stat_t stat,
  output gdfs_pkg::gdfs_cmd_t     cmd
);
  import gdfs_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_A_DEG  = 13'b0000000000010,
    S_A_DEGW = 13'b0000000000100,
    S_A_SCAN = 13'b0000000001000,
    S_A_CMP  = 13'b0000000010000,
    S_A_RES  = 13'b0000000100000,
    S_Q_INIT = 13'b0000001000000,
    S_Q_DEG  = 13'b0000010000000,
    S_Q_DEGW = 13'b0000100000000,
    S_Q_STEP = 13'b0001000000000,
    S_Q_CHK  = 13'b0010000000000,
    S_Q_POPW = 13'b0100000000000,
    S_Q_FIN  = 13'b1000000000000
  } state_t;

  state_t      state_r, state_nxt;
  add_status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_ADDED;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    cmd            = '0;
    cmd.add_status = st_r;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = (in_command == CMD_QUERY) ? S_Q_INIT : S_A_DEG;
        end
      end
      S_A_DEG: begin
        if (!(stat.a_ok && stat.b_ok)) begin
          st_nxt    = ST_FULL;
          state_nxt = S_A_RES;
        end else begin
          cmd.deg_rd = 1'b1;
          state_nxt  = S_A_DEGW;
        end
      end
      S_A_DEGW: begin
        cmd.deg_load = 1'b1;
        cmd.idx_clr  = 1'b1;
        state_nxt    = S_A_SCAN;
      end
      S_A_SCAN: begin
        if (stat.idx_lt_deg) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_A_CMP;
        end else if (stat.deg_full) begin
          st_nxt    = ST_FULL;
          state_nxt = S_A_RES;
        end else begin
          cmd.nb_wr = 1'b1;
          st_nxt    = ST_ADDED;
          state_nxt = S_A_RES;
        end
      end
      S_A_CMP: begin
        if (stat.nb_match) begin
          st_nxt    = ST_PRESENT;
          state_nxt = S_A_RES;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_A_SCAN;
        end
      end
      S_A_RES: begin
        if (stat.out_free) begin
          cmd.emit_add = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_nxt  = stat.a_ok ? S_Q_DEG : S_Q_FIN;
      end
      S_Q_DEG: begin
        cmd.deg_rd      = 1'b1;
        cmd.deg_sel_cur = 1'b1;
        state_nxt       = S_Q_DEGW;
      end
      S_Q_DEGW: begin
        cmd.deg_load    = 1'b1;
        cmd.deg_sel_cur = 1'b1;
        state_nxt       = S_Q_STEP;
      end
      S_Q_STEP: begin
        if (!stat.cur_done) begin
          cmd.nb_rd        = 1'b1;
          cmd.nb_sel_query = 1'b1;
          cmd.cur_inc      = 1'b1;
          state_nxt        = S_Q_CHK;
        end else if (stat.stack_empty) begin
          state_nxt = S_Q_FIN;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_Q_POPW;
        end
      end
      S_Q_CHK: begin
        if (stat.w_visited) begin
          state_nxt = S_Q_STEP;
        end else if (stat.out_free) begin
          cmd.emit_edge = 1'b1;
          cmd.push      = 1'b1;
          state_nxt     = S_Q_DEG;
        end
      end
      S_Q_POPW: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_Q_DEG;
      end
      S_Q_FIN: begin
        if (stat.out_free) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/gdfs_dp.sv
// Datapath of the reachability core: tables, stack, visited marks, result register.
// Uses gdfs_pkg and gdfs_ram; steered by gdfs_ctrl through the command struct.
`default_nettype none
module gdfs_dp #(
  parameter int VERTEX_COUNT = gdfs_pkg::VERTEX_COUNT_DEF,
  parameter int MAX_DEGREE   = gdfs_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gdfs_pkg::gdfs_cmd_t cmd,
  output gdfs_pkg::gdfs_stat_t     stat,
  input  wire logic                in_command,
  input  wire logic [3:0]          in_vertex_a,
  input  wire logic [3:0]          in_vertex_b,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [1:0]               out_status,
  output logic [3:0]               out_edge_from,
  output logic [3:0]               out_edge_to,
  output logic                     out_reachable,
  output logic                     out_last
);
  import gdfs_pkg::*;

  localparam int VW = $clog2(VERTEX_COUNT);
  localparam int PW = $clog2(MAX_DEGREE + 1);
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int TW = $clog2(VERTEX_COUNT + 1);
  localparam int NB_DEPTH = VERTEX_COUNT << DW;

  logic                    cmd_r;
  logic [3:0]              a_r, b_r;
  logic [VW-1:0]           cur_v_r, cur_v_nxt;
  logic [PW-1:0]           cur_p_r, cur_p_nxt;
  logic [PW-1:0]           deg_r, idx_r;
  logic [TW-1:0]           top_r, top_m1;
  logic                    found_r;
  logic [VERTEX_COUNT-1:0] visited_r, visited_nxt, dval_r;
  logic                    out_valid_r;
  logic [1:0]              kind_r, status_r;
  logic [3:0]              efrom_r, eto_r;
  logic                    reach_r, last_r;

  logic [VW-1:0]           a_v, w_v, deg_v;
  logic [PW-1:0]           deg_rd;
  logic [3:0]              nb_rd;
  logic [VW+PW-1:0]        stk_rd;
  logic                    out_free;

  assign a_v    = VW'(a_r);
  assign w_v    = VW'(nb_rd);
  assign deg_v  = cmd.deg_sel_cur ? cur_v_r : a_v;
  assign top_m1 = top_r - 1'b1;
  assign out_free = !out_valid_r || out_ready;

  gdfs_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_deg_ram (
    .clk     (clk),
    .wr_en   (cmd.nb_wr),
    .wr_addr (a_v),
    .wr_data (deg_r + 1'b1),
    .rd_en   (cmd.deg_rd),
    .rd_addr (deg_v),
    .rd_data (deg_rd)
  );

  gdfs_ram #(.WIDTH(4), .DEPTH(NB_DEPTH)) u_nb_ram (
    .clk     (clk),
    .wr_en   (cmd.nb_wr),
    .wr_addr ({a_v, deg_r[DW-1:0]}),
    .wr_data (b_r),
    .rd_en   (cmd.nb_rd),
    .rd_addr (cmd.nb_sel_query ? {cur_v_r, cur_p_r[DW-1:0]} : {a_v, idx_r[DW-1:0]}),
    .rd_data (nb_rd)
  );

  gdfs_ram #(.WIDTH(VW + PW), .DEPTH(VERTEX_COUNT)) u_stk_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (top_r[VW-1:0]),
    .wr_data ({cur_v_r, cur_p_r}),
    .rd_en   (cmd.pop_rd),
    .rd_addr (top_m1[VW-1:0]),
    .rd_data (stk_rd)
  );

  always_comb begin
    stat.is_query    = (cmd_r == CMD_QUERY);
    stat.a_ok        = int'(a_r) < VERTEX_COUNT;
    stat.b_ok        = int'(b_r) < VERTEX_COUNT;
    stat.idx_lt_deg  = idx_r < deg_r;
    stat.deg_full    = int'(deg_r) >= MAX_DEGREE;
    stat.cur_done    = cur_p_r >= deg_r;
    stat.stack_empty = (top_r == '0);
    stat.nb_match    = (nb_rd == b_r);
    stat.w_visited   = visited_r[w_v];
    stat.out_free    = out_free;
  end

  always_comb begin
    cur_v_nxt = cur_v_r;
    cur_p_nxt = cur_p_r;
    if (cmd.q_init) begin
      cur_v_nxt = a_v;
      cur_p_nxt = '0;
    end else if (cmd.push) begin
      cur_v_nxt = w_v;
      cur_p_nxt = '0;
    end else if (cmd.pop_load) begin
      {cur_v_nxt, cur_p_nxt} = stk_rd;
    end else if (cmd.cur_inc) begin
      cur_p_nxt = cur_p_r + 1'b1;
    end
  end

  always_comb begin
    visited_nxt = visited_r;
    if (cmd.q_init) begin
      visited_nxt = '0;
      if (stat.a_ok) begin
        visited_nxt[a_v] = 1'b1;
      end
    end else if (cmd.push) begin
      visited_nxt[w_v] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_command;
      a_r   <= in_vertex_a;
      b_r   <= in_vertex_b;
    end
    if (cmd.deg_load) begin
      deg_r <= dval_r[deg_v] ? deg_rd : '0;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    cur_v_r <= cur_v_nxt;
    cur_p_r <= cur_p_nxt;
    if (cmd.emit_add || cmd.emit_edge || cmd.emit_fin) begin
      kind_r   <= cmd.emit_add ? KIND_ADD : (cmd.emit_edge ? KIND_EDGE : KIND_FINAL);
      status_r <= cmd.emit_add ? cmd.add_status : ST_ADDED;
      efrom_r  <= cmd.emit_edge ? 4'(cur_v_r) : 4'd0;
      eto_r    <= cmd.emit_edge ? nb_rd : 4'd0;
      reach_r  <= cmd.emit_fin & found_r;
      last_r   <= !cmd.emit_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      found_r     <= 1'b0;
      visited_r   <= '0;
      dval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      visited_r <= visited_nxt;
      if (cmd.q_init) begin
        top_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.push) begin
        top_r <= top_r + 1'b1;
        if (nb_rd == b_r) begin
          found_r <= 1'b1;
        end
      end else if (cmd.pop_rd) begin
        top_r <= top_m1;
      end
      if (cmd.nb_wr) begin
        dval_r[a_v] <= 1'b1;
      end
      if (cmd.emit_add || cmd.emit_edge || cmd.emit_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_status    = status_r;
  assign out_edge_from = efrom_r;
  assign out_edge_to   = eto_r;
  assign out_reachable = reach_r;
  assign out_last      = last_r;

  a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_add, cmd.emit_edge, cmd.emit_fin}))
    else $error("more than one result loaded in one cycle");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_add || cmd.emit_edge || cmd.emit_fin) |-> out_free)
    else $error("result register overwritten before it was taken");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (int'(top_r) < VERTEX_COUNT))
    else $error("stack overflow");
  a_push_new: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> visited_r[cur_v_r])
    else $error("pushed vertex not marked visited");
endmodule
`default_nettype wire

FILE: hdl/graph_dfs_reachability_core.sv
// Depth-first reachability core: neighbor lists with add and query requests.
// An add scans the neighbor list one entry at a time, limited by the one-read neighbor RAM.
// A query reads the degree of each vertex entered, checks each neighbor entry in turn and pops when a list is done.
// One request is in work at a time; the result register frees the input side early.
// Reset is synchronous and active low; it empties all lists at once, no clearing pass.
// Uses gdfs_pkg, gdfs_if, gdfs_ram, gdfs_ctrl and gdfs_dp.
`default_nettype none
module graph_dfs_reachability_core #(
  parameter int VERTEX_COUNT = gdfs_pkg::VERTEX_COUNT_DEF,
  parameter int MAX_DEGREE   = gdfs_pkg::MAX_DEGREE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gdfs_in_if.sink    in_req,
  gdfs_out_if.source out_res
);
  import gdfs_pkg::*;

  gdfs_cmd_t  cmd;
  gdfs_stat_t stat;

  gdfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (in_req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  gdfs_dp #(.VERTEX_COUNT(VERTEX_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_req.command),
    .in_vertex_a   (in_req.vertex_a),
    .in_vertex_b   (in_req.vertex_b),
    .out_valid     (out_res.valid),
    .out_ready     (out_res.ready),
    .out_kind      (out_res.kind),
    .out_status    (out_res.status),
    .out_edge_from (out_res.edge_from),
    .out_edge_to   (out_res.edge_to),
    .out_reachable (out_res.reachable),
    .out_last      (out_res.last)
  );
endmodule
`default_nettype wire

FILE: bench/tb_graph_dfs_reachability_core.sv
// Testbench for graph_dfs_reachability_core: adds and depth-first queries
// driven through the request channel, every result checked against a local predictor.
// Depends on gdfs_pkg, gdfs_if and the core RTL.
`default_nettype none
module tb_graph_dfs_reachability_core;
  import gdfs_pkg::*;

  localparam int NV = 16;
  localparam int MD = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic       command;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
  } request_t;

  typedef struct packed {
    kind_t       kind;
    add_status_t status;
    logic [3:0]  edge_from;
    logic [3:0]  edge_to;
    logic        reachable;
    logic        last;
  } result_t;

  typedef struct {
    request_t req;
    logic     has_known;
    result_t  known;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  bit   quiet = 1'b0;

  gdfs_in_if  in_ch();
  gdfs_out_if out_ch();

  graph_dfs_reachability_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_ch.sink), .out_res(out_ch.source)
  );

  always #5 clk = ~clk;

  logic [3:0] adj_list [NV][MD];
  int         adj_len [NV];
  result_t    expected_results[$];
  result_t    known_results[$];
  bit         known_valid[$];

  function automatic result_t make_result(kind_t k, add_status_t s, logic [3:0] f,
                                          logic [3:0] t, logic r, logic l);
    result_t x;
    x.kind = k; x.status = s; x.edge_from = f; x.edge_to = t;
    x.reachable = r; x.last = l;
    return x;
  endfunction

  task automatic predict_request(input request_t rq);
    bit         seen [NV];
    logic [3:0] stk_v [NV];
    int         stk_p [NV];
    int         top;
    int         n;
    bit         found;
    add_status_t st;
    logic [3:0] v;
    logic [3:0] w;
    if (rq.command == CMD_ADD) begin
      st = ST_ADDED;
      for (int i = 0; i < adj_len[rq.vertex_a]; i++)
        if (adj_list[rq.vertex_a][i] == rq.vertex_b) st = ST_PRESENT;
      if (st == ST_ADDED && adj_len[rq.vertex_a] >= MD) st = ST_FULL;
      if (st == ST_ADDED) begin
        adj_list[rq.vertex_a][adj_len[rq.vertex_a]] = rq.vertex_b;
        adj_len[rq.vertex_a]++;
      end
      expected_results.push_back(make_result(KIND_ADD, st, 4'd0, 4'd0, 1'b0, 1'b1));
    end else begin
      foreach (seen[i]) seen[i] = 1'b0;
      found = 1'b0;
      n = 0;
      seen[rq.vertex_a] = 1'b1;
      stk_v[0] = rq.vertex_a;
      stk_p[0] = 0;
      top = 1;
      while (top > 0) begin
        v = stk_v[top-1];
        if (stk_p[top-1] >= adj_len[v]) begin
          top--;
        end else begin
          w = adj_list[v][stk_p[top-1]];
          stk_p[top-1]++;
          if (!seen[w]) begin
            seen[w] = 1'b1;
            if (w == rq.vertex_b) found = 1'b1;
            if (n < 15) begin
              expected_results.push_back(make_result(KIND_EDGE, ST_ADDED, v, w, 1'b0, 1'b0));
              n++;
            end
            if (top < NV) begin
              stk_v[top] = w;
              stk_p[top] = 0;
              top++;
            end
          end
        end
      end
      expected_results.push_back(make_result(KIND_FINAL, ST_ADDED, 4'd0, 4'd0, found, 1'b1));
    end
  endtask

  task automatic send_request(input request_t rq, input bit has_known, input result_t kr);
    while (!quiet && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= rq.command;
    in_ch.vertex_a <= rq.vertex_a;
    in_ch.vertex_b <= rq.vertex_b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(rq);
    known_results.push_back(kr);
    known_valid.push_back(has_known);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic request_t make_req(logic c, logic [3:0] a, logic [3:0] b);
    request_t r;
    r.command = c; r.vertex_a = a; r.vertex_b = b;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (rst_n) begin
      out_ch.ready <= quiet || ($urandom_range(99) >= 29);
      if (out_ch.valid && out_ch.ready) begin
        got = make_result(kind_t'(out_ch.kind), add_status_t'(out_ch.status),
                          out_ch.edge_from, out_ch.edge_to, out_ch.reachable, out_ch.last);
        if (expected_results.size() == 0) begin
          $error("result with none expected: kind %0d", got.kind);
          error_count++;
        end else begin
          exp = expected_results.pop_front();
          if (got.last && known_valid.size() > 0) begin
            if (known_valid.pop_front() && got != known_results[0]) begin
              $error("directed row mismatch: expected %h actual %h", known_results[0], got);
              error_count++;
            end
            void'(known_results.pop_front());
          end
          if (got.kind != exp.kind) begin
            $error("kind: expected %0d actual %0d", exp.kind, got.kind); error_count++;
          end
          if (got.status != exp.status) begin
            $error("status: expected %0d actual %0d", exp.status, got.status); error_count++;
          end
          if (got.edge_from != exp.edge_from) begin
            $error("edge_from: expected %0d actual %0d", exp.edge_from, got.edge_from);
            error_count++;
          end
          if (got.edge_to != exp.edge_to) begin
            $error("edge_to: expected %0d actual %0d", exp.edge_to, got.edge_to); error_count++;
          end
          if (got.reachable != exp.reachable) begin
            $error("reachable: expected %0d actual %0d", exp.reachable, got.reachable);
            error_count++;
          end
          if (got.last != exp.last) begin
            $error("last: expected %0d actual %0d", exp.last, got.last); error_count++;
          end
        end
      end
    end
  end

  initial begin
    row_t    rows[$];
    result_t none;
    int      hub;
    none = make_result(KIND_ADD, ST_ADDED, 4'd0, 4'd0, 1'b0, 1'b0);
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.vertex_a = 4'd0;
    in_ch.vertex_b = 4'd0;
    out_ch.ready = 1'b0;
    foreach (adj_len[i]) adj_len[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Query on an empty graph, then a chain, a self loop, a duplicate and a full list.
    rows.push_back('{make_req(CMD_QUERY, 4'd0, 4'd15), 1'b1,
                     make_result(KIND_FINAL, ST_ADDED, 4'd0, 4'd0, 1'b0, 1'b1)});
    rows.push_back('{make_req(CMD_ADD, 4'd0, 4'd15), 1'b1,
                     make_result(KIND_ADD, ST_ADDED, 4'd0, 4'd0, 1'b0, 1'b1)});
    rows.push_back('{make_req(CMD_ADD, 4'd0, 4'd15), 1'b1,
                     make_result(KIND_ADD, ST_PRESENT, 4'd0, 4'd0, 1'b0, 1'b1)});
    rows.push_back('{make_req(CMD_ADD, 4'd15, 4'd15), 1'b1,
                     make_result(KIND_ADD, ST_ADDED, 4'd0, 4'd0, 1'b0, 1'b1)});
    rows.push_back('{make_req(CMD_ADD, 4'd15, 4'd0), 1'b0, none});
    rows.push_back('{make_req(CMD_QUERY, 4'd0, 4'd15), 1'b0, none});
    rows.push_back('{make_req(CMD_QUERY, 4'd0, 4'd0), 1'b0, none});
    rows.push_back('{make_req(CMD_QUERY, 4'd7, 4'd7), 1'b1,
                     make_result(KIND_FINAL, ST_ADDED, 4'd0, 4'd0, 1'b0, 1'b1)});
    for (int i = 0; i < 16; i++)
      rows.push_back('{make_req(CMD_ADD, 4'd5, 4'(15 - i)), 1'b1,
                       make_result(KIND_ADD, ST_ADDED, 4'd0, 4'd0, 1'b0, 1'b1)});
    rows.push_back('{make_req(CMD_ADD, 4'd5, 4'd3), 1'b1,
                     make_result(KIND_ADD, ST_PRESENT, 4'd0, 4'd0, 1'b0, 1'b1)});
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_known, rows[i].known);
    send_request(make_req(CMD_QUERY, 4'd5, 4'd9), 1'b0, none);

    // The sender waits here until every expected result is back.
    drain;
    for (int i = 0; i < 20; i++)
      send_request(make_req(CMD_QUERY, 4'($urandom_range(15)), 4'($urandom_range(15))),
                   1'b0, none);

    // Random graphs: mostly adds with queries between, one stretch with no idling.
    for (int i = 0; i < 55; i++) begin
      quiet = (i >= 20 && i < 35);
      hub = $urandom_range(15);
      if ($urandom_range(99) < 60)
        send_request(make_req(CMD_ADD, ($urandom_range(3) == 0) ? 4'(hub) :
                              4'($urandom_range(15)), 4'($urandom_range(15))), 1'b0, none);
      else
        send_request(make_req(CMD_QUERY, 4'($urandom_range(15)), 4'($urandom_range(15))),
                     1'b0, none);
    end
    quiet = 1'b0;
    drain;
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
